### rtl/clrs_pkg.sv
// Package with the request codes, status codes and cell control types of the C-LOOK scheduler.
`default_nettype none
package clrs_pkg;

  // Request kinds as they arrive on the input channel.
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE   = 2'd2;
  // The fourth kind code has no meaning; such a request is dropped.
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  // Status codes returned with every result.
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_DISPATCHED = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_NO_TAG     = 3'd5;

  // Operation broadcast to every cell of the queue.
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_REMOVE   = 2'd2
  } op_t;

  // Control group sent from the sequencer to the cells.
  typedef struct packed {
    op_t  op;
    logic cmp_en;    // Cells evaluate their match bit.
    logic apply_en;  // Cells shift or load.
    logic use_all;   // Dispatch wrap: every valid cell counts as a match.
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/clrs_cell.sv
// One slot of the sorted request queue, with its compare logic and neighbor links.
`default_nettype none
module clrs_cell
  import clrs_pkg::*;
#(
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cell_ctrl_t             ctrl,
  input  wire [SECTOR_BITS-1:0]  key_sector,
  input  wire [TAG_BITS-1:0]     key_tag,
  input  wire                    new_wr,
  // Left neighbor (lower sector), used when the queue opens a gap.
  input  wire                    left_valid,
  input  wire [SECTOR_BITS-1:0]  left_sector,
  input  wire                    left_wr,
  input  wire [TAG_BITS-1:0]     left_tag,
  // Right neighbor (higher sector), used when the queue closes a gap.
  input  wire                    right_valid,
  input  wire [SECTOR_BITS-1:0]  right_sector,
  input  wire                    right_wr,
  input  wire [TAG_BITS-1:0]     right_tag,
  // Match chains running from the head of the queue.
  input  wire                    pfx_in,
  input  wire                    ge_in,
  output logic                   pfx_out,
  output logic                   ge_out,
  output logic                   sel,
  output logic                   hit,
  output logic                   valid,
  output logic [SECTOR_BITS-1:0] sector,
  output logic                   wr,
  output logic [TAG_BITS-1:0]    tag
);

  logic                   valid_r;
  logic [SECTOR_BITS-1:0] sector_r;
  logic                   wr_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic                   hit_r;
  logic                   hit_nxt;
  logic                   eff;

  // Match condition for the current operation.
  always_comb begin
    case (ctrl.op)
      OP_ADD:      hit_nxt = !valid_r || (sector_r > key_sector);
      OP_DISPATCH: hit_nxt = valid_r && (sector_r > key_sector);
      OP_REMOVE:   hit_nxt = valid_r && (tag_r == key_tag);
      default:     hit_nxt = 1'b0;
    endcase
  end

  // The first matching cell along the chain is the selected one.
  always_comb begin
    eff     = ctrl.use_all ? valid_r : hit_r;
    sel     = eff && !pfx_in;
    pfx_out = pfx_in || eff;
    ge_out  = ge_in || sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit_r <= hit_nxt;
    end
  end

  // Valid bit: insert shifts toward the tail, delete shifts toward the head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.apply_en) begin
      if (ctrl.op == OP_ADD) begin
        if (eff) begin
          valid_r <= pfx_in ? left_valid : 1'b1;
        end
      end else if (ge_out) begin
        valid_r <= right_valid;
      end
    end
  end

  // Payload follows the same moves as the valid bit.
  always_ff @(posedge clk) begin
    if (ctrl.apply_en) begin
      if (ctrl.op == OP_ADD) begin
        if (eff && pfx_in) begin
          sector_r <= left_sector;
          wr_r     <= left_wr;
          tag_r    <= left_tag;
        end else if (eff) begin
          sector_r <= key_sector;
          wr_r     <= new_wr;
          tag_r    <= key_tag;
        end
      end else if (ge_out) begin
        sector_r <= right_sector;
        wr_r     <= right_wr;
        tag_r    <= right_tag;
      end
    end
  end

  assign hit    = hit_r;
  assign valid  = valid_r;
  assign sector = sector_r;
  assign wr     = wr_r;
  assign tag    = tag_r;

endmodule
`default_nettype wire

### rtl/clook_request_scheduler.sv
// Top level of the C-LOOK request scheduler: sequencer, cell chain and result register.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_tvalid/tready   | tuser kind, tdata sector/write/tag
//   out_    | output    | out_tvalid/tready  | tuser status, tdata sector/write/tag
//
// Every request goes through accept, compare in all cells, then shift and
// load the result register, with the cell compare registered before the first-match ripple.
// A request of the unused kind is consumed in its accept cycle with no result.
// The apply step waits while the previous result is still untaken; input is
// accepted again in the cycle after apply. Reset empties the queue at once.
`default_nettype none
module clook_request_scheduler
  import clrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: end_sector, is_write, request_tag, zero fill.
  input  wire [((SECTOR_BITS+TAG_BITS+8)/8)*8-1:0] in_tdata,
  // Fields from bit 0: kind.
  input  wire [1:0]              in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // Fields from bit 0: out_sector, out_is_write, out_tag, zero fill.
  output logic [((SECTOR_BITS+TAG_BITS+8)/8)*8-1:0] out_tdata,
  // Fields from bit 0: status.
  output logic [2:0]             out_tuser
);

  localparam int DATA_W = ((SECTOR_BITS + TAG_BITS + 8) / 8) * 8;
  localparam int PAY_W  = SECTOR_BITS + 1 + TAG_BITS;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r;
  logic [SECTOR_BITS-1:0] sec_r;
  logic                   wr_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic [SECTOR_BITS-1:0] last_r;
  logic [CNT_W-1:0]       count_r;
  logic                   out_valid_r;
  logic [2:0]             out_status_r;
  logic [SECTOR_BITS-1:0] out_sector_r;
  logic                   out_wr_r;
  logic [TAG_BITS-1:0]    out_tag_r;

  cell_ctrl_t             ctrl;
  logic                   in_fire;
  logic                   adv;
  logic                   any_hit;
  logic                   full;
  logic                   empty;
  logic                   do_apply;
  logic [SECTOR_BITS-1:0] key_sector;
  logic [SECTOR_BITS-1:0] pick_sector;
  logic                   pick_wr;
  logic [TAG_BITS-1:0]    pick_tag;

  logic [QUEUE_DEPTH-1:0] c_valid;
  logic [QUEUE_DEPTH-1:0] c_wr;
  logic [QUEUE_DEPTH-1:0] c_hit;
  logic [QUEUE_DEPTH-1:0] c_sel;
  logic [SECTOR_BITS-1:0] c_sector [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    c_tag    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   pfx;
  logic [QUEUE_DEPTH:0]   ge;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign adv       = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign any_hit   = |c_hit;
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);

  // Apply only when the request changes the queue.
  always_comb begin
    case (op_r)
      OP_ADD:      do_apply = !full;
      OP_DISPATCH: do_apply = !empty;
      OP_REMOVE:   do_apply = any_hit;
      default:     do_apply = 1'b0;
    endcase
  end

  // Cell control and compare key.
  always_comb begin
    ctrl.op       = op_r;
    ctrl.cmp_en   = (state_r == S_CMP);
    ctrl.apply_en = adv && do_apply;
    ctrl.use_all  = (op_r == OP_DISPATCH) && !any_hit;
    key_sector    = (op_r == OP_DISPATCH) ? last_r : sec_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && in_tuser != KIND_UNUSED) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: if (adv) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the accepted request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (in_tuser)
        KIND_ADD:      op_r <= OP_ADD;
        KIND_DISPATCH: op_r <= OP_DISPATCH;
        KIND_REMOVE:   op_r <= OP_REMOVE;
        default:       op_r <= OP_REMOVE;
      endcase
      sec_r <= in_tdata[SECTOR_BITS-1:0];
      wr_r  <= in_tdata[SECTOR_BITS];
      tag_r <= in_tdata[PAY_W-1:SECTOR_BITS+1];
    end
  end

  // Cell chain; the head holds the lowest sector.
  assign pfx[0] = 1'b0;
  assign ge[0]  = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   lv, rv, lw, rw;
    logic [SECTOR_BITS-1:0] ls, rs;
    logic [TAG_BITS-1:0]    lt, rt;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign ls = '0;
      assign lw = 1'b0;
      assign lt = '0;
    end else begin : g_mid_l
      assign lv = c_valid[i-1];
      assign ls = c_sector[i-1];
      assign lw = c_wr[i-1];
      assign lt = c_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rs = '0;
      assign rw = 1'b0;
      assign rt = '0;
    end else begin : g_mid_r
      assign rv = c_valid[i+1];
      assign rs = c_sector[i+1];
      assign rw = c_wr[i+1];
      assign rt = c_tag[i+1];
    end

    clrs_cell #(
      .SECTOR_BITS(SECTOR_BITS),
      .TAG_BITS   (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .key_sector  (key_sector),
      .key_tag     (tag_r),
      .new_wr      (wr_r),
      .left_valid  (lv),
      .left_sector (ls),
      .left_wr     (lw),
      .left_tag    (lt),
      .right_valid (rv),
      .right_sector(rs),
      .right_wr    (rw),
      .right_tag   (rt),
      .pfx_in      (pfx[i]),
      .ge_in       (ge[i]),
      .pfx_out     (pfx[i+1]),
      .ge_out      (ge[i+1]),
      .sel         (c_sel[i]),
      .hit         (c_hit[i]),
      .valid       (c_valid[i]),
      .sector      (c_sector[i]),
      .wr          (c_wr[i]),
      .tag         (c_tag[i])
    );
  end

  // Gather the selected cell's payload; at most one cell is selected.
  always_comb begin
    pick_sector = '0;
    pick_wr     = 1'b0;
    pick_tag    = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pick_sector = pick_sector | (c_sector[i] & {SECTOR_BITS{c_sel[i]}});
      pick_wr     = pick_wr | (c_wr[i] & c_sel[i]);
      pick_tag    = pick_tag | (c_tag[i] & {TAG_BITS{c_sel[i]}});
    end
  end

  // Fill count and last dispatched sector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      last_r  <= '0;
    end else if (ctrl.apply_en) begin
      if (op_r == OP_ADD) begin
        count_r <= count_r + 1'b1;
      end else begin
        count_r <= count_r - 1'b1;
      end
      if (op_r == OP_DISPATCH) begin
        last_r <= pick_sector;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sector_r <= '0;
      out_wr_r     <= 1'b0;
      out_tag_r    <= '0;
      case (op_r)
        OP_ADD: begin
          out_status_r <= full ? ST_FULL : ST_ADDED;
        end
        OP_DISPATCH: begin
          out_status_r <= empty ? ST_EMPTY : ST_DISPATCHED;
          if (!empty) begin
            out_sector_r <= pick_sector;
            out_wr_r     <= pick_wr;
            out_tag_r    <= pick_tag;
          end
        end
        OP_REMOVE: begin
          out_status_r <= any_hit ? ST_REMOVED : ST_NO_TAG;
        end
        default: begin
          out_status_r <= ST_NO_TAG;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(DATA_W-PAY_W){1'b0}}, out_tag_r, out_wr_r, out_sector_r};

  // The fill count never passes the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above queue depth");

  // Valid cells match the fill count.
  a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(c_valid) == int'(count_r))
    else $error("valid cells disagree with fill count");

  // Valid cells form one run from the head of the queue.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, c_valid} + 1'b1) || (&c_valid))
    else $error("gap in valid cells");

  // A queued add grows the queue by one.
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.apply_en && op_r == OP_ADD) |=> (count_r == $past(count_r) + 1'b1))
    else $error("add did not grow the queue");

endmodule
`default_nettype wire

### test/clook_request_scheduler_tb.sv
// Self-checking testbench of the C-LOOK request scheduler with a built-in queue predictor.
`default_nettype none
module clook_request_scheduler_tb;
  import clrs_pkg::*;

  localparam int DEPTH        = 32;
  localparam int SECTOR_W     = 48;
  localparam int TAG_W        = 8;
  localparam int DATA_W       = ((SECTOR_W + TAG_W + 8) / 8) * 8;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 20;

  localparam logic [SECTOR_W-1:0] MAX_SECTOR = '1;

  typedef struct packed {
    logic [2:0]          status;
    logic [SECTOR_W-1:0] sector;
    logic                wr;
    logic [TAG_W-1:0]    tag;
  } sched_result_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SECTOR_W-1:0] sector;
    logic                wr;
    logic [TAG_W-1:0]    tag;
    logic                typed;  // Expected result is written in the row.
    sched_result_t       want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  // Directed requests: empty queue, extremes, equal sectors, wrap, duplicate tags.
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b1, '{ST_EMPTY,      48'd0,      1'b0, 8'd0}},
    '{KIND_REMOVE,   48'd0,      1'b0, 8'd0,   1'b1, '{ST_NO_TAG,     48'd0,      1'b0, 8'd0}},
    '{KIND_ADD,      MAX_SECTOR, 1'b1, 8'd255, 1'b1, '{ST_ADDED,      48'd0,      1'b0, 8'd0}},
    '{KIND_ADD,      48'd0,      1'b0, 8'd0,   1'b1, '{ST_ADDED,      48'd0,      1'b0, 8'd0}},
    '{KIND_ADD,      48'd100,    1'b1, 8'd7,   1'b0, '0},
    '{KIND_ADD,      48'd100,    1'b0, 8'd8,   1'b0, '0},
    '{KIND_UNUSED,   MAX_SECTOR, 1'b1, 8'd255, 1'b0, '0},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b0, '0},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b1, '{ST_DISPATCHED, MAX_SECTOR, 1'b1, 8'd255}},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b1, '{ST_DISPATCHED, 48'd0,      1'b0, 8'd0}},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b0, '0},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b1, '{ST_EMPTY,      48'd0,      1'b0, 8'd0}},
    '{KIND_ADD,      48'd50,     1'b1, 8'd9,   1'b0, '0},
    '{KIND_ADD,      48'd50,     1'b0, 8'd9,   1'b0, '0},
    '{KIND_ADD,      48'd20,     1'b1, 8'd9,   1'b0, '0},
    '{KIND_ADD,      48'h8000_0000_0000, 1'b0, 8'd128, 1'b0, '0},
    '{KIND_REMOVE,   48'd0,      1'b0, 8'd9,   1'b1, '{ST_REMOVED,    48'd0,      1'b0, 8'd0}},
    '{KIND_REMOVE,   48'd0,      1'b0, 8'd200, 1'b1, '{ST_NO_TAG,     48'd0,      1'b0, 8'd0}},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b0, '0},
    '{KIND_REMOVE,   48'd0,      1'b0, 8'd9,   1'b0, '0},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b0, '0},
    '{KIND_DISPATCH, 48'd0,      1'b0, 8'd0,   1'b1, '{ST_EMPTY,      48'd0,      1'b0, 8'd0}}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic [1:0]        in_tuser   = KIND_ADD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [2:0]        out_tuser;

  // Predictor state: the sorted request queue and the head position.
  logic [SECTOR_W-1:0] queued_sector [DEPTH];
  logic                queued_write  [DEPTH];
  logic [TAG_W-1:0]    queued_tag    [DEPTH];
  int                  queued_count    = 0;
  logic [SECTOR_W-1:0] last_dispatched = '0;

  sched_result_t awaited_results [$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            sent_count  = 0;
  bit            tx_burst    = 1'b0;
  bit            rx_burst    = 1'b0;

  clook_request_scheduler #(
    .QUEUE_DEPTH (DEPTH),
    .SECTOR_BITS (SECTOR_W),
    .TAG_BITS    (TAG_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Applies one request to the predicted queue. Returns 0 when the request yields no result.
  function automatic bit clook_schedule(input logic [1:0] kind,
                                        input logic [SECTOR_W-1:0] sector,
                                        input logic wr, input logic [TAG_W-1:0] tag,
                                        output sched_result_t res);
    int  pos;
    bit  found;
    res   = '0;
    found = 1'b0;
    pos   = 0;
    case (kind)
      KIND_ADD: begin
        if (queued_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // Insert after every entry whose sector is not above the new one.
          pos = queued_count;
          for (int i = 0; i < queued_count; i++) begin
            if (!found && queued_sector[i] > sector) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (int i = queued_count; i > pos; i--) begin
            queued_sector[i] = queued_sector[i-1];
            queued_write[i]  = queued_write[i-1];
            queued_tag[i]    = queued_tag[i-1];
          end
          queued_sector[pos] = sector;
          queued_write[pos]  = wr;
          queued_tag[pos]    = tag;
          queued_count++;
          res.status = ST_ADDED;
        end
      end
      KIND_DISPATCH: begin
        if (queued_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // First entry beyond the head, or the lowest one when the sweep wraps.
          for (int i = 0; i < queued_count; i++) begin
            if (!found && queued_sector[i] > last_dispatched) begin
              pos   = i;
              found = 1'b1;
            end
          end
          res.status      = ST_DISPATCHED;
          res.sector      = queued_sector[pos];
          res.wr          = queued_write[pos];
          res.tag         = queued_tag[pos];
          last_dispatched = queued_sector[pos];
          found           = 1'b1;
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < queued_count; i++) begin
          if (!found && queued_tag[i] == tag) begin
            pos   = i;
            found = 1'b1;
          end
        end
        res.status = found ? ST_REMOVED : ST_NO_TAG;
      end
      default: return 1'b0;
    endcase
    // Close the gap left by a dispatched or removed entry.
    if (found && kind != KIND_ADD) begin
      for (int i = pos; i + 1 < queued_count; i++) begin
        queued_sector[i] = queued_sector[i+1];
        queued_write[i]  = queued_write[i+1];
        queued_tag[i]    = queued_tag[i+1];
      end
      queued_count--;
    end
    return 1'b1;
  endfunction

  // Presents one request after a random gap and records its predicted result.
  task automatic send_request(input logic [1:0] kind, input logic [SECTOR_W-1:0] sector,
                              input logic wr, input logic [TAG_W-1:0] tag,
                              input logic typed, input sched_result_t want);
    int            gap;
    sched_result_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= DATA_W'({tag, wr, sector});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (clook_schedule(kind, sector, wr, tag, res)) begin
      awaited_results.push_back(typed ? want : res);
    end
  endtask

  // One random request; the mode leans the mix toward filling, draining or churn.
  task automatic send_random(input int mode);
    int                  roll;
    logic [1:0]          kind;
    logic [SECTOR_W-1:0] sector;
    logic                wr;
    logic [TAG_W-1:0]    tag;
    logic [63:0]         wide;
    roll = $urandom_range(0, 99);
    case (mode)
      0:       kind = (roll < 80) ? KIND_ADD : (roll < 90) ? KIND_DISPATCH : KIND_REMOVE;
      1:       kind = (roll < 10) ? KIND_ADD : (roll < 85) ? KIND_DISPATCH : KIND_REMOVE;
      default: kind = (roll < 40) ? KIND_ADD : (roll < 75) ? KIND_DISPATCH : KIND_REMOVE;
    endcase
    if ($urandom_range(0, 49) == 0) kind = KIND_UNUSED;
    wide = {$urandom, $urandom};
    roll = $urandom_range(0, 9);
    // Small sectors collide often; others span the range, sit at the top or sit at the head.
    if (roll < 5)       sector = SECTOR_W'($urandom_range(0, 63));
    else if (roll < 8)  sector = wide[SECTOR_W-1:0];
    else if (roll == 8) sector = MAX_SECTOR;
    else                sector = last_dispatched + SECTOR_W'($urandom_range(0, 2));
    wr  = 1'($urandom_range(0, 1));
    tag = $urandom_range(0, 1) ? TAG_W'($urandom_range(0, 15)) : TAG_W'($urandom_range(0, 255));
    if (kind == KIND_REMOVE && queued_count > 0 && $urandom_range(0, 9) < 7) begin
      tag = queued_tag[$urandom_range(0, queued_count - 1)];
    end
    send_request(kind, sector, wr, tag, 1'b0, '0);
    if (kind != KIND_UNUSED) sent_count++;
  endtask

  // Result side: random stalls, then compare against the oldest prediction.
  initial begin
    sched_result_t got;
    sched_result_t want;
    int            stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.status = out_tuser;
      got.sector = out_tdata[SECTOR_W-1:0];
      got.wr     = out_tdata[SECTOR_W];
      got.tag    = out_tdata[SECTOR_W+TAG_W:SECTOR_W+1];
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", got.status));
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.sector !== want.sector)
          report_mismatch($sformatf("sector got %h want %h", got.sector, want.sector));
        if (got.wr !== want.wr)
          report_mismatch($sformatf("write got %b want %b", got.wr, want.wr));
        if (got.tag !== want.tag)
          report_mismatch($sformatf("tag got %0d want %0d", got.tag, want.tag));
      end
    end
  end

  // Request side: reset, directed table, random phases, then drain and finish.
  initial begin
    int mode;
    int phase_len;
    int phase;
    phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(DIR_TABLE[r].kind, DIR_TABLE[r].sector, DIR_TABLE[r].wr,
                   DIR_TABLE[r].tag, DIR_TABLE[r].typed, DIR_TABLE[r].want);
    end

    while (sent_count < RANDOM_ITEMS) begin
      mode      = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 80);
      tx_burst  = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_random(mode);
      // Now and then hold off until every pending result has come back.
      if (phase == 0 || $urandom_range(0, 4) == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
